// ===== rtl/tssd_pkg.sv =====
// Shared types and constants for the touch strip swipe detector.
// No dependencies; every other file of the block imports this package.

package tssd_pkg;

   localparam int PAD_W    = 16;
   localparam int SCAN_W   = 8;
   localparam int POS_W    = 4;
   localparam int GAP_W    = 4;
   localparam int COUNT_W  = 8;
   localparam int ACCUM_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int RSP_DATA_W = 8;

   localparam logic [POS_W-1:0]   RESET_WINDOW_LOW  = 4'd0;
   localparam logic [POS_W-1:0]   RESET_WINDOW_HIGH = 4'd8;
   localparam logic [COUNT_W-1:0] RESET_IDLE_LIMIT  = 8'd250;
   localparam logic [COUNT_W-1:0] RESET_HOLD_LIMIT  = 8'd50;
   localparam logic [COUNT_W-1:0] COUNT_MAX         = 8'hFF;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_LOW  = 2'd0,
      CSR_WINDOW_HIGH = 2'd1,
      CSR_IDLE_LIMIT  = 2'd2,
      CSR_HOLD_LIMIT  = 2'd3
   } csr_index_type;

   // Direction codes, two bit signed.
   localparam logic [1:0] DIR_NONE  = 2'b00;
   localparam logic [1:0] DIR_POS   = 2'b01;
   localparam logic [1:0] DIR_NEG   = 2'b11;

   typedef struct packed {
      logic             any;
      logic [GAP_W-1:0] left_gap;
      logic [GAP_W-1:0] right_gap;
   } scan_type;

   typedef struct packed {
      logic       is_touched;
      logic       is_done;
      logic       is_held;
      logic       is_right;
      logic       is_left;
      logic [1:0] direction;
   } result_type;

endpackage

// ===== rtl/tssd_edge_scan.sv =====
// Window masking and edge scan of one touch sample.
// Depends on tssd_pkg for widths and the scan result struct.

module tssd_edge_scan
   import tssd_pkg::*;
(
   input  logic [SCAN_W-1:0] pads,
   input  logic [POS_W-1:0]  window_low,
   input  logic [POS_W-1:0]  window_high,
   output scan_type          scan
);

   logic [SCAN_W-1:0] masked;
   logic [2:0]        msb_pos;
   logic [2:0]        lsb_pos;
   logic [POS_W:0]    left_gap_wide;
   logic [POS_W:0]    right_gap_wide;

   always_comb begin
      for (int i = 0; i < SCAN_W; i++) begin
         masked[i] = pads[i] && (POS_W'(i) >= window_low) && (POS_W'(i) < window_high);
      end
   end

   // Highest and lowest set pad inside the window.
   always_comb begin
      msb_pos = '0;
      lsb_pos = '0;
      for (int i = 0; i < SCAN_W; i++) begin
         if (masked[i]) begin
            msb_pos = 3'(i);
         end
      end
      for (int i = SCAN_W - 1; i >= 0; i--) begin
         if (masked[i]) begin
            lsb_pos = 3'(i);
         end
      end
   end

   // Only meaningful when some pad is set, so both gaps stay below 15.
   assign left_gap_wide  = {1'b0, window_high} - (POS_W+1)'(1) - {2'b00, msb_pos};
   assign right_gap_wide = {2'b00, lsb_pos} - {1'b0, window_low};

   assign scan.any       = |masked;
   assign scan.left_gap  = left_gap_wide[GAP_W-1:0];
   assign scan.right_gap = right_gap_wide[GAP_W-1:0];

endmodule

// ===== rtl/tssd_track.sv =====
// Gesture tracking state: accumulators, edge counts, hold and idle counters.
// Depends on tssd_pkg; takes the scan of the current item from tssd_edge_scan.

module tssd_track
   import tssd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [PAD_W-1:0]   sample,
   input  scan_type           scan,
   input  logic [COUNT_W-1:0] idle_limit,
   input  logic [COUNT_W-1:0] hold_limit,
   output result_type         result
);

   logic [ACCUM_W-1:0] left_accum_ff,  left_accum_in;
   logic [ACCUM_W-1:0] right_accum_ff, right_accum_in;
   logic [GAP_W-1:0]   last_lgap_ff,   last_lgap_in;
   logic [GAP_W-1:0]   last_rgap_ff,   last_rgap_in;
   logic [PAD_W-1:0]   last_sample_ff, last_sample_in;
   logic [COUNT_W-1:0] hold_ff,        hold_in;
   logic [COUNT_W-1:0] idle_ff,        idle_in;
   logic               done_ff,        done_in;

   logic [ACCUM_W-1:0] base_left;
   logic [ACCUM_W-1:0] base_right;
   logic [GAP_W-1:0]   base_lgap;
   logic [GAP_W-1:0]   base_rgap;
   logic [PAD_W-1:0]   base_sample;
   logic [COUNT_W-1:0] base_hold;
   logic [COUNT_W-1:0] base_idle;
   logic [COUNT_W-1:0] idle_inc;
   logic [ACCUM_W:0]   full_sum;
   logic [ACCUM_W-1:0] wrap_sum;

   // A touch after a finished gesture starts from a cleared state.
   always_comb begin
      base_left   = done_ff ? '0 : left_accum_ff;
      base_right  = done_ff ? '0 : right_accum_ff;
      base_lgap   = done_ff ? '0 : last_lgap_ff;
      base_rgap   = done_ff ? '0 : last_rgap_ff;
      base_sample = done_ff ? '0 : last_sample_ff;
      base_hold   = done_ff ? '0 : hold_ff;
      base_idle   = done_ff ? '0 : idle_ff;
   end

   assign idle_inc = (idle_ff == COUNT_MAX) ? COUNT_MAX : idle_ff + 8'd1;

   always_comb begin
      left_accum_in  = left_accum_ff;
      right_accum_in = right_accum_ff;
      last_lgap_in   = last_lgap_ff;
      last_rgap_in   = last_rgap_ff;
      last_sample_in = last_sample_ff;
      hold_in        = hold_ff;
      idle_in        = idle_ff;
      done_in        = done_ff;
      if (!scan.any) begin
         idle_in = idle_inc;
         done_in = done_ff || (idle_inc == idle_limit);
      end else begin
         left_accum_in  = base_left;
         right_accum_in = base_right;
         last_lgap_in   = base_lgap;
         last_rgap_in   = base_rgap;
         last_sample_in = base_sample;
         idle_in        = base_idle;
         done_in        = 1'b0;
         if (sample == base_sample) begin
            hold_in = (base_hold == COUNT_MAX) ? COUNT_MAX : base_hold + 8'd1;
         end else begin
            hold_in        = '0;
            idle_in        = '0;
            left_accum_in  = base_left + {4'b0000, scan.left_gap} - {4'b0000, base_lgap};
            right_accum_in = base_right - {4'b0000, scan.right_gap} + {4'b0000, base_rgap};
            last_lgap_in   = scan.left_gap;
            last_rgap_in   = scan.right_gap;
            last_sample_in = sample;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_accum_ff  <= '0;
         right_accum_ff <= '0;
         last_lgap_ff   <= '0;
         last_rgap_ff   <= '0;
         last_sample_ff <= '0;
         hold_ff        <= '0;
         idle_ff        <= '0;
         done_ff        <= 1'b0;
      end else if (step) begin
         left_accum_ff  <= left_accum_in;
         right_accum_ff <= right_accum_in;
         last_lgap_ff   <= last_lgap_in;
         last_rgap_ff   <= last_rgap_in;
         last_sample_ff <= last_sample_in;
         hold_ff        <= hold_in;
         idle_ff        <= idle_in;
         done_ff        <= done_in;
      end
   end

   // The result describes the state after this item's update.
   assign full_sum = {left_accum_in[ACCUM_W-1], left_accum_in}
                   + {right_accum_in[ACCUM_W-1], right_accum_in};
   assign wrap_sum = left_accum_in + right_accum_in;

   always_comb begin
      if (wrap_sum == '0) begin
         result.direction = DIR_NONE;
      end else if (wrap_sum[ACCUM_W-1]) begin
         result.direction = DIR_NEG;
      end else begin
         result.direction = DIR_POS;
      end
      // Halving truncates toward zero, so a sum of plus or minus one reads as zero.
      result.is_left    = $signed(full_sum) <= -9'sd2;
      result.is_right   = $signed(full_sum) >= 9'sd2;
      result.is_held    = hold_in > hold_limit;
      result.is_done    = done_in;
      result.is_touched = (idle_in == '0);
   end

   a_done_means_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (idle_ff != '0))
      else $error("done flag set while idle count is zero");

   a_gap_range: assert property (@(posedge clock) disable iff (reset)
      (last_lgap_ff != 4'hF) && (last_rgap_ff[3] == 1'b0))
      else $error("stored edge count out of range");

   a_change_clears: assert property (@(posedge clock) disable iff (reset)
      step && scan.any && (sample != base_sample) |=> (hold_ff == '0) && (idle_ff == '0))
      else $error("changed touch did not clear the counters");

   a_idle_counts: assert property (@(posedge clock) disable iff (reset)
      step && !scan.any && (idle_ff != COUNT_MAX)
      |=> (idle_ff == COUNT_W'($past(idle_ff) + 8'd1)))
      else $error("idle item did not advance the idle counter");

endmodule

// ===== rtl/touch_strip_swipe_detector_top.sv =====
// Top level of the touch strip swipe detector: configuration registers,
// input register and result register around tssd_edge_scan and tssd_track.
// An item goes from the input register to the result register, which drives rsp.
// One item per cycle while rsp_tready is high; tracking state loads with the result.
// Reset clears the pipeline, the tracking state and loads register defaults.
// No clearing pass: the block takes items as soon as reset is released.

module touch_strip_swipe_detector_top
   import tssd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PAD_W-1:0]      req_tdata,   // [15:0] pad_bits
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [1:0] direction, [2] is_left,
                                              // [3] is_right, [4] is_held,
                                              // [5] is_done, [6] is_touched, [7] zero
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [POS_W-1:0]   win_low_ff;
   logic [POS_W-1:0]   win_high_ff;
   logic [COUNT_W-1:0] idle_limit_ff;
   logic [COUNT_W-1:0] hold_limit_ff;

   logic               in_valid_ff;
   logic [PAD_W-1:0]   in_sample_ff;
   logic               rsp_valid_ff;
   result_type         rsp_result_ff;

   logic       advance;
   logic       step;
   scan_type   scan;
   result_type result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_low_ff    <= RESET_WINDOW_LOW;
         win_high_ff   <= RESET_WINDOW_HIGH;
         idle_limit_ff <= RESET_IDLE_LIMIT;
         hold_limit_ff <= RESET_HOLD_LIMIT;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_WINDOW_LOW:  win_low_ff    <= csr_data[POS_W-1:0];
            CSR_WINDOW_HIGH: win_high_ff   <= csr_data[POS_W-1:0];
            CSR_IDLE_LIMIT:  idle_limit_ff <= csr_data;
            CSR_HOLD_LIMIT:  hold_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The whole pipe moves whenever the result register is free or being drained.
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_sample_ff <= req_tdata;
      end
      if (step) begin
         rsp_result_ff <= result;
      end
   end

   tssd_edge_scan u_scan (
      .pads        (in_sample_ff[SCAN_W-1:0]),
      .window_low  (win_low_ff),
      .window_high (win_high_ff),
      .scan        (scan)
   );

   tssd_track u_track (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .sample     (in_sample_ff),
      .scan       (scan),
      .idle_limit (idle_limit_ff),
      .hold_limit (hold_limit_ff),
      .result     (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_result_ff};

endmodule

// ===== sim/touch_strip_swipe_detector_top_tb.sv =====
// Self-checking testbench for touch_strip_swipe_detector_top, with a cycle-free predictor
// of the swipe tracking state. Depends only on tssd_pkg and the top-level module.

module touch_strip_swipe_detector_top_tb
   import tssd_pkg::*;
();

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PAD_W-1:0]      req_tdata = '0;      // [15:0] pad_bits
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;           // [1:0] direction, [2] is_left, [3] is_right,
                                               // [4] is_held, [5] is_done, [6] is_touched
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   touch_strip_swipe_detector_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor copy of the configuration and the tracking state.
   logic [POS_W-1:0]   win_low  = RESET_WINDOW_LOW;
   logic [POS_W-1:0]   win_high = RESET_WINDOW_HIGH;
   logic [COUNT_W-1:0] idle_lim = RESET_IDLE_LIMIT;
   logic [COUNT_W-1:0] hold_lim = RESET_HOLD_LIMIT;

   logic [ACCUM_W-1:0] sum_left = '0;
   logic [ACCUM_W-1:0] sum_right = '0;
   logic [GAP_W-1:0]   prev_left_gap = '0;
   logic [GAP_W-1:0]   prev_right_gap = '0;
   logic [PAD_W-1:0]   prev_sample = '0;
   logic [COUNT_W-1:0] hold_cnt = '0;
   logic [COUNT_W-1:0] idle_cnt = '0;
   logic               gesture_done = 1'b0;

   result_type pending_swipes[$];
   int         fail_count = 0;
   bit         gaps_on = 1'b0;
   bit         stalls_on = 1'b0;
   int         rsp_hold_off = 0;
   int         rsp_stall = 0;
   int         pads_sent = 0;

   function automatic bit pad_set(logic [PAD_W-1:0] pads, int k);
      return (k < SCAN_W) ? pads[k] : 1'b0;
   endfunction

   function automatic void clear_tracking();
      sum_left = '0;
      sum_right = '0;
      prev_left_gap = '0;
      prev_right_gap = '0;
      prev_sample = '0;
      hold_cnt = '0;
      idle_cnt = '0;
      gesture_done = 1'b0;
   endfunction

   function automatic result_type predict_swipe(logic [PAD_W-1:0] pads);
      bit                 any = 1'b0;
      int                 lo, hi, i;
      int                 gl = 0;
      int                 gr = 0;
      int                 total;
      logic [ACCUM_W-1:0] wrap_sum;
      result_type         r;
      lo = int'(win_low);
      hi = int'(win_high);
      for (i = lo; i < hi; i++)
         if (pad_set(pads, i)) any = 1'b1;
      if (!any) begin
         if (idle_cnt != COUNT_MAX) idle_cnt++;
         if (idle_cnt == idle_lim) gesture_done = 1'b1;
      end else begin
         if (gesture_done) clear_tracking();
         if (pads == prev_sample) begin
            if (hold_cnt != COUNT_MAX) hold_cnt++;
         end else begin
            idle_cnt = '0;
            hold_cnt = '0;
            for (i = hi; i > lo && !pad_set(pads, i - 1); i--) gl++;
            for (i = lo; i < hi && !pad_set(pads, i); i++) gr++;
            sum_left = sum_left + ACCUM_W'(gl) - ACCUM_W'(prev_left_gap);
            sum_right = sum_right - ACCUM_W'(gr) + ACCUM_W'(prev_right_gap);
            prev_left_gap = GAP_W'(gl);
            prev_right_gap = GAP_W'(gr);
            prev_sample = pads;
         end
      end
      // The direction uses the wrapped 8-bit sum, the left/right flags the full sum.
      total = int'($signed(sum_left)) + int'($signed(sum_right));
      wrap_sum = sum_left + sum_right;
      r.direction = ($signed(wrap_sum) > 0) ? DIR_POS :
                    (($signed(wrap_sum) < 0) ? DIR_NEG : DIR_NONE);
      r.is_left = (total / 2) < 0;
      r.is_right = (total / 2) > 0;
      r.is_held = hold_cnt > hold_lim;
      r.is_done = gesture_done;
      r.is_touched = idle_cnt == 0;
      return r;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result receiver: a requested long hold-off wins over the random stalls.
   always @(negedge clock) begin
      int n;
      if (rsp_hold_off > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_off <= rsp_hold_off - 1;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         n = stalls_on ? pick_gap() : 0;
         rsp_tready <= (n == 0);
         rsp_stall <= (n > 0) ? n - 1 : 0;
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = result_type'(rsp_tdata[6:0]);
         if (pending_swipes.size() == 0) begin
            $error("result item with no expected result waiting");
            fail_count++;
         end else begin
            want = pending_swipes.pop_front();
            check_field("direction", want.direction, got.direction);
            check_field("is_left", want.is_left, got.is_left);
            check_field("is_right", want.is_right, got.is_right);
            check_field("is_held", want.is_held, got.is_held);
            check_field("is_done", want.is_done, got.is_done);
            check_field("is_touched", want.is_touched, got.is_touched);
         end
      end
   end

   task automatic send_pad(logic [PAD_W-1:0] pads);
      int n;
      n = gaps_on ? pick_gap() : 0;
      @(negedge clock);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pads;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_swipes.push_back(predict_swipe(pads));
      pads_sent++;
   endtask

   // Stops offering items and waits until every expected result has come back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_swipes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_WINDOW_LOW:  win_low = value[POS_W-1:0];
         CSR_WINDOW_HIGH: win_high = value[POS_W-1:0];
         CSR_IDLE_LIMIT:  idle_lim = value;
         CSR_HOLD_LIMIT:  hold_lim = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_window(int lo, int hi);
      write_register(CSR_WINDOW_LOW, CSR_DATA_W'(lo));
      write_register(CSR_WINDOW_HIGH, CSR_DATA_W'(hi));
   endtask

   // One pad group sliding across the strip, with some holds, then an idle tail.
   task automatic send_swipe();
      int               width, pos, steps, stride, reps, tail, s, i;
      bit               leftward;
      logic [PAD_W-1:0] pads;
      logic [SCAN_W-1:0] mask;
      width = $urandom_range(1, 3);
      steps = $urandom_range(2, 9);
      leftward = 1'($urandom_range(0, 1));
      pos = leftward ? 0 : 7;
      for (s = 0; s < steps && pos >= 0 && pos <= 7; s++) begin
         pads = PAD_W'(((1 << width) - 1) << pos);
         if ($urandom_range(0, 4) == 0) pads[15:8] = 8'($urandom);
         reps = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 8) : $urandom_range(0, 1);
         repeat (1 + reps) send_pad(pads);
         stride = $urandom_range(1, 2);
         pos = leftward ? pos + stride : pos - stride;
      end
      mask = '0;
      for (i = int'(win_low); i < int'(win_high) && i < SCAN_W; i++) mask[i] = 1'b1;
      tail = (idle_lim != 0 && idle_lim <= 12 && $urandom_range(0, 1)) ?
             int'(idle_lim) + $urandom_range(0, 2) : $urandom_range(0, 3);
      repeat (tail) send_pad({8'($urandom), 8'($urandom) & ~mask});
   endtask

   task automatic test_directed_swipes();
      send_pad(16'h0001);
      send_pad(16'h0080);
      send_pad(16'h0080);
      send_pad(16'h8080);
      send_pad(16'hFFFF);
      send_pad(16'h0000);
      send_pad(16'h0100);
      send_pad(16'h0018);
      send_pad(16'h00FF);
   endtask

   task automatic test_hold_and_done();
      write_register(CSR_HOLD_LIMIT, 8'd0);
      write_register(CSR_IDLE_LIMIT, 8'd1);
      send_pad(16'h0004);
      send_pad(16'h0004);
      send_pad(16'h0000);
      send_pad(16'h0000);
      send_pad(16'h0002);
      send_pad(16'h0002);
   endtask

   task automatic test_window_extremes();
      set_window(3, 6);
      send_pad(16'h0038);
      send_pad(16'h0007);
      send_pad(16'h00C0);
      set_window(8, 15);
      send_pad(16'h00FF);
      set_window(6, 2);
      send_pad(16'h00FF);
      set_window(0, 15);
      send_pad(16'h0080);
      send_pad(16'h0001);
      set_window(15, 15);
      send_pad(16'hFFFF);
   endtask

   // Both counters run into their ceiling.
   task automatic test_counter_saturation();
      set_window(0, 8);
      write_register(CSR_IDLE_LIMIT, 8'd0);
      write_register(CSR_HOLD_LIMIT, 8'd254);
      repeat (260) send_pad(16'h0010);
      write_register(CSR_HOLD_LIMIT, 8'd255);
      write_register(CSR_IDLE_LIMIT, 8'd255);
      send_pad(16'h0010);
      repeat (258) send_pad({8'($urandom), 8'h00});
      send_pad(16'h0020);
   endtask

   // The receiver stops for a long while so the block backs up into its input.
   task automatic test_backpressure();
      gaps_on = 1'b0;
      drain();
      rsp_hold_off = 60;
      repeat (30) send_pad(16'($urandom));
   endtask

   task automatic run_random_phase(int lo, int hi, int idle, int hold, int quota, bit idling);
      int stop_at;
      // Window registers keep only the low bits; the upper ones are noise.
      write_register(CSR_WINDOW_LOW, {4'($urandom), 4'(lo)});
      write_register(CSR_WINDOW_HIGH, {4'($urandom), 4'(hi)});
      write_register(CSR_IDLE_LIMIT, 8'(idle));
      write_register(CSR_HOLD_LIMIT, 8'(hold));
      gaps_on = idling;
      stalls_on = idling;
      stop_at = pads_sent + quota;
      while (pads_sent < stop_at) begin
         if ($urandom_range(0, 4) == 0) send_pad(16'($urandom));
         else send_swipe();
      end
   endtask

   task automatic test_random_gestures();
      int p, lo;
      run_random_phase(0, 8, 3, 2, 50, 1'b0);
      run_random_phase(2, 6, 1, 0, 50, 1'b1);
      run_random_phase(0, 15, 255, 254, 40, 1'b1);
      run_random_phase(5, 3, 0, 255, 20, 1'b1);
      for (p = 0; p < 4; p++) begin
         lo = $urandom_range(0, 6);
         run_random_phase(lo, $urandom_range(lo + 1, 9), $urandom_range(1, 10),
                          $urandom_range(0, 6), 25, 1'b1);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_swipes();
      test_hold_and_done();
      test_window_extremes();
      test_counter_saturation();
      test_backpressure();
      test_random_gestures();
      drain();
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== touch_strip_swipe_detector_top.f =====
rtl/tssd_pkg.sv
rtl/tssd_edge_scan.sv
rtl/tssd_track.sv
rtl/touch_strip_swipe_detector_top.sv
sim/touch_strip_swipe_detector_top_tb.sv
